/* design/sip_pkg.sv */
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants of the segment intersection point block
// Payload structs of both channels, the job that passes from the geometry
// front end to the divider back end, and the derived datapath widths.
// ----------------------------------------------------------------------------
package sip_pkg;

  // coordinate width of every input and output point field
  localparam int COORD_BITS = 16;

  // line coefficients a and b
  localparam int AW  = COORD_BITS + 1;
  // coordinate by coordinate product
  localparam int CPW = 2 * COORD_BITS;
  // line constant c
  localparam int CVW = 2 * COORD_BITS + 1;
  // c splits into an unsigned low part of KL bits and a signed high part
  localparam int KL  = COORD_BITS + 1;
  localparam int CHW = CVW - KL;
  // coefficient by coordinate product and the side value sum
  localparam int SPW = AW + COORD_BITS;
  localparam int SW  = SPW + 2;
  // coefficient by coefficient product and the denominator
  localparam int DPW = 2 * AW;
  localparam int DW  = DPW + 1;
  // partial products of the numerators
  localparam int PHW = AW + CHW;
  localparam int PLW = AW + KL + 1;
  // quotient bits and numerator width
  localparam int QB  = COORD_BITS + 1;
  localparam int NW  = DW + QB;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax0;
    logic signed [COORD_BITS-1:0] ay0;
    logic signed [COORD_BITS-1:0] ax1;
    logic signed [COORD_BITS-1:0] ay1;
    logic signed [COORD_BITS-1:0] bx0;
    logic signed [COORD_BITS-1:0] by0;
    logic signed [COORD_BITS-1:0] bx1;
    logic signed [COORD_BITS-1:0] by1;
  } seg_pair_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } cross_pt_t;

  typedef struct packed {
    logic                 hit;
    logic signed [NW-1:0] num_x;
    logic signed [NW-1:0] num_y;
    logic signed [DW-1:0] den;
  } div_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // both values nonzero and of the same sign
  function automatic logic same_side(logic signed [SW-1:0] p, logic signed [SW-1:0] q);
    return (p != '0) && (q != '0) && (p[SW-1] == q[SW-1]);
  endfunction

endpackage

/* design/segment_intersection_point.sv */
// ----------------------------------------------------------------------------
// segment_intersection_point: crossing point of two integer segments
// Usage:
//   The seg channel carries one pair of segments per beat (endpoints of
//   segment a and segment b). The pt channel returns one beat per pair: hit,
//   and the crossing point rounded to nearest, or hit low and a zero point
//   for a rejected, parallel, collinear or degenerate pair.
//   Both channels move a beat on a rising edge with valid high and stall low.
//   From the seg beat to pt valid a pair passes four geometry stages, one
//   queue slot, rounding, range check, one divider stage per quotient bit
//   (COORD_BITS + 1) and the output register. The divider stages are fully
//   pipelined; throughput is one pair per cycle unless pt_stall holds the result.
//   With pt_valid and pt_stall high the result and divider pipeline hold, while
//   the front end keeps accepting into a four-entry queue; seg_stall rises
//   only once that queue is full and the front end is backed up.
//   Reset empties the pipeline and the queue; no other state is kept.
// ----------------------------------------------------------------------------
module segment_intersection_point (
  input  logic                clk,
  input  logic                rst,
  input  logic                seg_valid,
  output logic                seg_stall,
  input  sip_pkg::seg_pair_t  seg,
  output logic                pt_valid,
  input  logic                pt_stall,
  output sip_pkg::cross_pt_t  pt
);
  import sip_pkg::*;

  logic     push, pop;
  div_job_t wr_job, rd_job;
  q_stat_t  qs;

  // classify and form numerators
  sip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg),
    .qs        (qs),
    .push      (push),
    .job       (wr_job)
  );

  // decouple front and back
  sip_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .qs     (qs)
  );

  // round, divide, saturate
  sip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qs       (qs),
    .pop      (pop),
    .job      (rd_job),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .pt       (pt)
  );

endmodule

/* design/sip_front.sv */
// ----------------------------------------------------------------------------
// sip_front: geometry front end
// Four stages form the line equations, the side values, the denominator and
// both numerators, and classify the pair as hit or no hit.
// ----------------------------------------------------------------------------
module sip_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_stall,
  input  sip_pkg::seg_pair_t seg,
  input  sip_pkg::q_stat_t   qs,
  output logic               push,
  output sip_pkg::div_job_t  job
);
  import sip_pkg::*;

  logic adv;
  logic v1, v2, v3, v4;

  // stage 1
  logic signed [AW-1:0]         a1, b1, a2, b2;
  logic signed [CPW-1:0]        m1, m2, m3, m4;
  logic signed [COORD_BITS-1:0] px0, py0, px1, py1, qx0, qy0, qx1, qy1;
  // stage 2
  logic signed [CVW-1:0]        c1, c2;
  logic signed [AW-1:0]         a1r, b1r, a2r, b2r;
  logic signed [SPW-1:0]        t1a, u1a, t1b, u1b, t2a, u2a, t2b, u2b;
  logic signed [DPW-1:0]        d1, d2;
  // stage 3
  logic signed [SW-1:0]         s1a, s1b, s2a, s2b;
  logic signed [DW-1:0]         den;
  logic signed [PHW-1:0]        hx1, hx2, hy1, hy2;
  logic signed [PLW-1:0]        lx1, lx2, ly1, ly2;
  // split line constants
  logic signed [CHW-1:0]        c1h, c2h;
  logic signed [KL:0]           c1l, c2l;
  // stage 4 inputs
  logic signed [NW-1:0]         nx, ny;
  logic                         rej;

  // advance the whole front unless the last beat cannot leave
  assign adv       = !(v4 && qs.full);
  assign seg_stall = !adv;
  assign push      = v4 && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= seg_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: coefficients and coordinate products
  always_ff @(posedge clk) begin
    if (adv) begin
      a1  <= AW'(seg.ay1) - AW'(seg.ay0);
      b1  <= AW'(seg.ax0) - AW'(seg.ax1);
      a2  <= AW'(seg.by1) - AW'(seg.by0);
      b2  <= AW'(seg.bx0) - AW'(seg.bx1);
      m1  <= CPW'(seg.ax1) * CPW'(seg.ay0);
      m2  <= CPW'(seg.ax0) * CPW'(seg.ay1);
      m3  <= CPW'(seg.bx1) * CPW'(seg.by0);
      m4  <= CPW'(seg.bx0) * CPW'(seg.by1);
      px0 <= seg.ax0;
      py0 <= seg.ay0;
      px1 <= seg.ax1;
      py1 <= seg.ay1;
      qx0 <= seg.bx0;
      qy0 <= seg.by0;
      qx1 <= seg.bx1;
      qy1 <= seg.by1;
    end
  end

  // stage 2: line constants, side products, denominator products
  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= CVW'(m1) - CVW'(m2);
      c2  <= CVW'(m3) - CVW'(m4);
      a1r <= a1;
      b1r <= b1;
      a2r <= a2;
      b2r <= b2;
      t1a <= SPW'(a1) * SPW'(qx0);
      u1a <= SPW'(b1) * SPW'(qy0);
      t1b <= SPW'(a1) * SPW'(qx1);
      u1b <= SPW'(b1) * SPW'(qy1);
      t2a <= SPW'(a2) * SPW'(px0);
      u2a <= SPW'(b2) * SPW'(py0);
      t2b <= SPW'(a2) * SPW'(px1);
      u2b <= SPW'(b2) * SPW'(py1);
      d1  <= DPW'(a1) * DPW'(b2);
      d2  <= DPW'(a2) * DPW'(b1);
    end
  end

  // split each line constant so the numerator products stay narrow
  assign c1h = $signed(c1[CVW-1:KL]);
  assign c2h = $signed(c2[CVW-1:KL]);
  assign c1l = $signed({1'b0, c1[KL-1:0]});
  assign c2l = $signed({1'b0, c2[KL-1:0]});

  // stage 3: side values, denominator, numerator partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      s1a <= SW'(t1a) + SW'(u1a) + SW'(c1);
      s1b <= SW'(t1b) + SW'(u1b) + SW'(c1);
      s2a <= SW'(t2a) + SW'(u2a) + SW'(c2);
      s2b <= SW'(t2b) + SW'(u2b) + SW'(c2);
      den <= DW'(d1) - DW'(d2);
      hx1 <= PHW'(b1r) * PHW'(c2h);
      hx2 <= PHW'(b2r) * PHW'(c1h);
      lx1 <= PLW'(b1r) * PLW'(c2l);
      lx2 <= PLW'(b2r) * PLW'(c1l);
      hy1 <= PHW'(a2r) * PHW'(c1h);
      hy2 <= PHW'(a1r) * PHW'(c2h);
      ly1 <= PLW'(a2r) * PLW'(c1l);
      ly2 <= PLW'(a1r) * PLW'(c2l);
    end
  end

  // stage 4: classify and assemble the numerators
  assign rej = same_side(s1a, s1b) || same_side(s2a, s2b);
  assign nx  = ((NW'(hx1) - NW'(hx2)) <<< KL) + NW'(lx1) - NW'(lx2);
  assign ny  = ((NW'(hy1) - NW'(hy2)) <<< KL) + NW'(ly1) - NW'(ly2);

  always_ff @(posedge clk) begin
    if (adv) begin
      job.hit   <= !rej && (den != '0);
      job.num_x <= nx;
      job.num_y <= ny;
      job.den   <= den;
    end
  end

endmodule

/* design/sip_queue.sv */
// ----------------------------------------------------------------------------
// sip_queue: job queue
// Short register queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module sip_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sip_pkg::div_job_t wr_job,
  input  logic              pop,
  output sip_pkg::div_job_t rd_job,
  output sip_pkg::q_stat_t  qs
);
  import sip_pkg::*;

  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QPW:0]   count;
  div_job_t       mem [QDEPTH];

  assign qs.full  = (count == (QPW+1)'(QDEPTH));
  assign qs.empty = (count == '0);
  assign rd_job   = mem[rd_ptr];

  // advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qs.empty) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qs.full) else $error("queue pushed while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPW+1)'(QDEPTH)) else $error("queue fill level out of range");

endmodule

/* design/sip_back.sv */
// ----------------------------------------------------------------------------
// sip_back: rounding divider back end
// Takes jobs from the queue, rounds the numerators, divides both by the
// denominator one quotient bit per stage, saturates and drives the result.
// ----------------------------------------------------------------------------
module sip_back (
  input  logic              clk,
  input  logic              rst,
  input  sip_pkg::q_stat_t  qs,
  output logic              pop,
  input  sip_pkg::div_job_t job,
  output logic              pt_valid,
  input  logic              pt_stall,
  output sip_pkg::cross_pt_t pt
);
  import sip_pkg::*;

  typedef struct packed {
    logic          hit;
    logic          sx;
    logic          sy;
    logic [NW-1:0] mx;
    logic [NW-1:0] my;
    logic [DW-1:0] dm;
  } pre_t;

  typedef struct packed {
    logic          hit;
    logic          sx;
    logic          sy;
    logic          ox;
    logic          oy;
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [DW-1:0] dm;
  } lane_t;

  logic          adv;
  logic          v0;
  logic [QB:0]   vs;
  pre_t          p0;
  lane_t         st [QB+1];
  logic [DW-1:0] dabs, half;
  logic [NW-1:0] nxa, nya;
  logic [NW-1:0] dlim;

  // saturate a signed quotient to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] to_coord(logic neg, logic ov,
                                                            logic [QB-1:0] qm);
    logic [QB-1:0] lim;
    lim = neg ? (QB'(1) << (COORD_BITS-1)) : ((QB'(1) << (COORD_BITS-1)) - 1'b1);
    if (ov || (qm > lim)) begin
      return neg ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return neg ? -qm[COORD_BITS-1:0] : qm[COORD_BITS-1:0];
  endfunction

  // hold the whole back end while the result beat waits
  assign adv = !(pt_valid && pt_stall);
  assign pop = adv && !qs.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      vs       <= '0;
      pt_valid <= 1'b0;
    end else if (adv) begin
      v0       <= !qs.empty;
      vs       <= {vs[QB-1:0], v0};
      pt_valid <= vs[QB];
    end
  end

  // magnitudes, round half away from zero
  assign dabs = job.den[DW-1] ? -job.den : job.den;
  assign half = dabs >> 1;
  assign nxa  = job.num_x[NW-1] ? -job.num_x : job.num_x;
  assign nya  = job.num_y[NW-1] ? -job.num_y : job.num_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      p0.hit <= job.hit;
      p0.sx  <= job.num_x[NW-1] ^ job.den[DW-1];
      p0.sy  <= job.num_y[NW-1] ^ job.den[DW-1];
      p0.mx  <= nxa + NW'(half);
      p0.my  <= nya + NW'(half);
      p0.dm  <= dabs;
    end
  end

  // flag quotients too large for the quotient bits
  assign dlim = NW'(p0.dm) << QB;

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].hit <= p0.hit;
      st[0].sx  <= p0.sx;
      st[0].sy  <= p0.sy;
      st[0].ox  <= (p0.mx >= dlim);
      st[0].oy  <= (p0.my >= dlim);
      st[0].rx  <= p0.mx;
      st[0].ry  <= p0.my;
      st[0].qx  <= '0;
      st[0].qy  <= '0;
      st[0].dm  <= p0.dm;
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int J = QB - 1 - k;
    logic [NW-1:0] shd;
    logic          gex, gey;
    lane_t         nxt;

    assign shd = NW'(st[k].dm) << J;
    assign gex = (st[k].rx >= shd);
    assign gey = (st[k].ry >= shd);

    always_comb begin
      nxt       = st[k];
      nxt.rx    = gex ? (st[k].rx - shd) : st[k].rx;
      nxt.ry    = gey ? (st[k].ry - shd) : st[k].ry;
      nxt.qx[J] = gex;
      nxt.qy[J] = gey;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  // apply sign, saturate, zero the point on a miss
  always_ff @(posedge clk) begin
    if (adv) begin
      pt.hit     <= st[QB].hit;
      pt.cross_x <= st[QB].hit ? to_coord(st[QB].sx, st[QB].ox, st[QB].qx) : '0;
      pt.cross_y <= st[QB].hit ? to_coord(st[QB].sy, st[QB].oy, st[QB].qy) : '0;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && pt_stall) |=> $stable(vs) && $stable(v0))
    else $error("divider pipeline moved while the result was stalled");
  a_hit_has_den: assert property (@(posedge clk) disable iff (rst)
    (vs[QB] && st[QB].hit) |-> (st[QB].dm != '0))
    else $error("hit job with zero denominator");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && !pt.hit) |-> ((pt.cross_x == '0) && (pt.cross_y == '0)))
    else $error("miss result carries a nonzero point");

endmodule
